/* rtl/dcl_pkg.sv */
// ----------------------------------------------------------------------------
// dcl_pkg: shared types and constants for the digit code lock entry unit
// Phase and button codes, ADC thresholds, register indexes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package dcl_pkg;

  // Number of code digits (default for the top-level parameter)
  localparam int unsigned DigitsDefault = 4;

  // Fixed field widths
  localparam int unsigned AdcW    = 10;
  localparam int unsigned RegW    = 16;
  localparam int unsigned CntW    = 17;
  localparam int unsigned NibW    = 4;
  localparam int unsigned CodeNib = RegW / NibW;
  localparam int unsigned CfgIdxW = 2;

  // Button ladder thresholds
  localparam logic [AdcW-1:0] AdcNoneMin  = AdcW'(1020);
  localparam logic [AdcW-1:0] AdcRightLim = AdcW'(100);
  localparam logic [AdcW-1:0] AdcUpLim    = AdcW'(300);
  localparam logic [AdcW-1:0] AdcDownLim  = AdcW'(550);
  localparam logic [AdcW-1:0] AdcLeftLim  = AdcW'(800);

  // Decimal digit range
  localparam int unsigned    DigitBase = 10;
  localparam logic [NibW-1:0] DigitMax = NibW'(DigitBase - 1);

  // Register reset values
  localparam logic [RegW-1:0] SecretRst   = RegW'(0);
  localparam logic [RegW-1:0] SampleRst   = RegW'(200);
  localparam logic [RegW-1:0] HoldRst     = RegW'(2000);
  localparam logic [RegW-1:0] BlinkRst    = RegW'(500);

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_ENTRY   = 3'd1,
    PH_CHECK   = 3'd2,
    PH_SHOW    = 3'd3,
    PH_SOLVED  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    BTN_NOT_SAMPLED = 3'd0,
    BTN_NONE        = 3'd1,
    BTN_RIGHT       = 3'd2,
    BTN_UP          = 3'd3,
    BTN_DOWN        = 3'd4,
    BTN_LEFT        = 3'd5,
    BTN_SELECT      = 3'd6
  } btn_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SECRET = 2'd0,
    CFG_SAMPLE = 2'd1,
    CFG_HOLD   = 2'd2,
    CFG_BLINK  = 2'd3
  } cfg_idx_e;

  // One result item
  typedef struct packed {
    phase_e          phase;
    logic [RegW-1:0] entered_code;
    logic [1:0]      cursor;
    logic            digit_visible;
    logic            code_correct;
    logic            solved;
    btn_e            button_seen;
  } res_t;

endpackage

`default_nettype wire

/* rtl/dcl_if.sv */
// ----------------------------------------------------------------------------
// dcl_if: handshake channels of the digit code lock entry unit
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcl_tick_if;
  logic                      valid;
  logic                      ready;
  logic [dcl_pkg::AdcW-1:0]  button_adc;

  modport source (output valid, output button_adc, input ready);
  modport sink   (input valid, input button_adc, output ready);
endinterface

interface dcl_result_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                phase;
  logic [dcl_pkg::RegW-1:0]  entered_code;
  logic [1:0]                cursor;
  logic                      digit_visible;
  logic                      code_correct;
  logic                      solved;
  logic [2:0]                button_seen;

  modport source (output valid, output phase, output entered_code, output cursor,
                  output digit_visible, output code_correct, output solved,
                  output button_seen, input ready);
  modport sink   (input valid, input phase, input entered_code, input cursor,
                  input digit_visible, input code_correct, input solved,
                  input button_seen, output ready);
endinterface

interface dcl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dcl_pkg::CfgIdxW-1:0] index;
  logic [dcl_pkg::RegW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/dcl_btn_dec.sv */
// ----------------------------------------------------------------------------
// dcl_btn_dec: button ladder decoder
// Maps one 10-bit ADC sample to a button code by threshold compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dcl_btn_dec (
  input  wire logic [dcl_pkg::AdcW-1:0] adc_i,
  output dcl_pkg::btn_e                 btn_o
);

  // Priority compare against the ladder thresholds
  always_comb begin
    if (adc_i >= dcl_pkg::AdcNoneMin) begin
      btn_o = dcl_pkg::BTN_NONE;
    end else if (adc_i < dcl_pkg::AdcRightLim) begin
      btn_o = dcl_pkg::BTN_RIGHT;
    end else if (adc_i < dcl_pkg::AdcUpLim) begin
      btn_o = dcl_pkg::BTN_UP;
    end else if (adc_i < dcl_pkg::AdcDownLim) begin
      btn_o = dcl_pkg::BTN_DOWN;
    end else if (adc_i < dcl_pkg::AdcLeftLim) begin
      btn_o = dcl_pkg::BTN_LEFT;
    end else begin
      btn_o = dcl_pkg::BTN_SELECT;
    end
  end

endmodule

`default_nettype wire

/* rtl/digit_code_lock_entry_unit.sv */
// ----------------------------------------------------------------------------
// digit_code_lock_entry_unit: combination lock entry stepped by 1 ms ticks
// Decodes button samples, edits digits, checks the code, blinks the cursor.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one item per millisecond tick, carrying the button ladder ADC sample.
//   out_o  : one result item per tick: phase, entered digits, cursor, blink state,
//            last compare result, solved flag and the button sampled on this tick.
//   cfg_i  : register writes (secret code, sample interval, result hold, blink
//            interval), index 0..3; always ready. Write only while idle.
// Latency: the result of a tick is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle while out_o is ready; the lock state and the
//   result register update in the same cycle via one pass of the phase sequencer.
// Stall: a result waiting at out_o is held; in_i stays ready while the result
//   register is empty or is being taken in that cycle, else it drops ready.
// Reset: phase init, digits and cursor zero, elapsed counters zero, digit
//   visible, compare flag set, registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_code_lock_entry_unit #(
  parameter int unsigned DIGITS = dcl_pkg::DigitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  dcl_tick_if.sink       in_i,
  dcl_result_if.source   out_o,
  dcl_cfg_if.sink        cfg_i
);

  localparam int unsigned CurW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CurW-1:0] CurLast = CurW'(DIGITS - 1);
  localparam logic [dcl_pkg::CntW-1:0] CntMax = {dcl_pkg::CntW{1'b1}};

  // Configuration registers
  logic [dcl_pkg::RegW-1:0] secret_q, sample_q, hold_q, blink_q;

  // Lock state
  dcl_pkg::phase_e                          phase_q, phase_d;
  logic [DIGITS-1:0][dcl_pkg::NibW-1:0]     digits_q, digits_d;
  logic [CurW-1:0]                          cursor_q, cursor_d;
  logic [dcl_pkg::CntW-1:0]                 smp_cnt_q, smp_cnt_d;
  logic [dcl_pkg::CntW-1:0]                 res_cnt_q, res_cnt_d;
  logic [dcl_pkg::CntW-1:0]                 blk_cnt_q, blk_cnt_d;
  logic                                     visible_q, visible_d;
  logic                                     match_q, match_d;

  // Result register
  logic          out_valid_q;
  dcl_pkg::res_t res_q, res_d;

  logic          in_acc;
  dcl_pkg::btn_e btn_dec;
  dcl_pkg::btn_e seen;
  logic [dcl_pkg::CntW-1:0] smp_inc, res_inc, blk_inc;
  logic [dcl_pkg::NibW-1:0] cur_digit;
  logic                     all_match;
  logic [dcl_pkg::RegW-1:0] packed_code;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  dcl_btn_dec u_btn_dec (
    .adc_i (in_i.button_adc),
    .btn_o (btn_dec)
  );

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secret_q <= dcl_pkg::SecretRst;
      sample_q <= dcl_pkg::SampleRst;
      hold_q   <= dcl_pkg::HoldRst;
      blink_q  <= dcl_pkg::BlinkRst;
    end else if (cfg_i.valid) begin
      case (dcl_pkg::cfg_idx_e'(cfg_i.index))
        dcl_pkg::CFG_SECRET: secret_q <= cfg_i.data;
        dcl_pkg::CFG_SAMPLE: sample_q <= cfg_i.data;
        dcl_pkg::CFG_HOLD:   hold_q   <= cfg_i.data;
        dcl_pkg::CFG_BLINK:  blink_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Saturating elapsed counters
  assign smp_inc = (smp_cnt_q == CntMax) ? CntMax : smp_cnt_q + 1'b1;
  assign res_inc = (res_cnt_q == CntMax) ? CntMax : res_cnt_q + 1'b1;
  assign blk_inc = (blk_cnt_q == CntMax) ? CntMax : blk_cnt_q + 1'b1;

  assign cur_digit = digits_q[cursor_q];

  // Compare every digit with its secret nibble; digits past the register see zero
  always_comb begin
    all_match = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (i < dcl_pkg::CodeNib) begin
        if (digits_q[i] != secret_q[i*dcl_pkg::NibW +: dcl_pkg::NibW]) all_match = 1'b0;
      end else if (digits_q[i] != '0) begin
        all_match = 1'b0;
      end
    end
  end

  // Phase sequencer: next state for one tick
  always_comb begin
    phase_d   = phase_q;
    digits_d  = digits_q;
    cursor_d  = cursor_q;
    smp_cnt_d = smp_inc;
    res_cnt_d = res_inc;
    blk_cnt_d = blk_inc;
    visible_d = visible_q;
    match_d   = match_q;
    seen      = dcl_pkg::BTN_NOT_SAMPLED;
    case (phase_q)
      dcl_pkg::PH_INIT: begin
        phase_d = dcl_pkg::PH_ENTRY;
      end
      dcl_pkg::PH_ENTRY: begin
        if (smp_inc > {1'b0, sample_q}) begin
          seen      = btn_dec;
          smp_cnt_d = '0;
          case (btn_dec)
            dcl_pkg::BTN_RIGHT: begin
              cursor_d = (cursor_q == CurLast) ? '0 : cursor_q + 1'b1;
            end
            dcl_pkg::BTN_LEFT: begin
              cursor_d = (cursor_q == '0) ? CurLast : cursor_q - 1'b1;
            end
            dcl_pkg::BTN_UP: begin
              digits_d[cursor_q] = (cur_digit == dcl_pkg::DigitMax) ? '0 : cur_digit + 1'b1;
            end
            dcl_pkg::BTN_DOWN: begin
              digits_d[cursor_q] = (cur_digit == '0) ? dcl_pkg::DigitMax : cur_digit - 1'b1;
            end
            dcl_pkg::BTN_SELECT: begin
              phase_d = dcl_pkg::PH_CHECK;
            end
            default: ;
          endcase
        end
        if (blk_inc > {1'b0, blink_q}) begin
          visible_d = !visible_q;
          blk_cnt_d = '0;
        end
      end
      dcl_pkg::PH_CHECK: begin
        match_d   = all_match;
        res_cnt_d = '0;
        phase_d   = dcl_pkg::PH_SHOW;
      end
      dcl_pkg::PH_SHOW: begin
        if (res_inc > {1'b0, hold_q}) begin
          phase_d = match_q ? dcl_pkg::PH_SOLVED : dcl_pkg::PH_INIT;
        end
      end
      default: begin
        phase_d = dcl_pkg::PH_SOLVED;
      end
    endcase
  end

  // Pack the first digits into the result code
  always_comb begin
    packed_code = '0;
    for (int i = 0; i < DIGITS && i < dcl_pkg::CodeNib; i++) begin
      packed_code[i*dcl_pkg::NibW +: dcl_pkg::NibW] = digits_d[i];
    end
  end

  always_comb begin
    res_d.phase         = phase_d;
    res_d.entered_code  = packed_code;
    res_d.cursor        = 2'(cursor_d);
    res_d.digit_visible = visible_d;
    res_d.code_correct  = match_d;
    res_d.solved        = (phase_d == dcl_pkg::PH_SOLVED);
    res_d.button_seen   = seen;
  end

  // Advance the lock state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dcl_pkg::PH_INIT;
      digits_q  <= '0;
      cursor_q  <= '0;
      smp_cnt_q <= '0;
      res_cnt_q <= '0;
      blk_cnt_q <= '0;
      visible_q <= 1'b1;
      match_q   <= 1'b1;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      digits_q  <= digits_d;
      cursor_q  <= cursor_d;
      smp_cnt_q <= smp_cnt_d;
      res_cnt_q <= res_cnt_d;
      blk_cnt_q <= blk_cnt_d;
      visible_q <= visible_d;
      match_q   <= match_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.phase         = res_q.phase;
  assign out_o.entered_code  = res_q.entered_code;
  assign out_o.cursor        = res_q.cursor;
  assign out_o.digit_visible = res_q.digit_visible;
  assign out_o.code_correct  = res_q.code_correct;
  assign out_o.solved        = res_q.solved;
  assign out_o.button_seen   = res_q.button_seen;

`ifndef SYNTHESIS
  a_solved_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dcl_pkg::PH_SOLVED |=> phase_q == dcl_pkg::PH_SOLVED)
    else $error("solved phase was left");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CurLast)
    else $error("cursor beyond last digit");

  a_seen_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.button_seen != dcl_pkg::BTN_NOT_SAMPLED |->
      (res_q.phase == dcl_pkg::PH_ENTRY || res_q.phase == dcl_pkg::PH_CHECK))
    else $error("button sampled outside entry");

  a_solved_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.solved == (res_q.phase == dcl_pkg::PH_SOLVED))
    else $error("solved flag disagrees with phase");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(phase_q) && $stable(digits_q))
    else $error("lock state moved while result stalled");
`endif

endmodule

`default_nettype wire

/* tb/sv/lock_result_checker.sv */
// ----------------------------------------------------------------------------
// lock_result_checker: result predictor and comparator for the lock entry unit
// Watches the tick, result and register channels. Each accepted tick item is
// run through a local model of the lock, and the expected result is queued.
// Each accepted result item is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module lock_result_checker
  import dcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dcl_tick_if         tick_i,
  dcl_result_if       res_i,
  dcl_cfg_if          cfg_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [RegW-1:0] secret_q;
  logic [RegW-1:0] sample_q;
  logic [RegW-1:0] hold_q;
  logic [RegW-1:0] blink_q;

  // Lock state copy
  phase_e          lock_phase;
  logic [NibW-1:0] digit_q [DigitsDefault];
  logic [1:0]      cursor_q;
  logic [CntW-1:0] since_sample_q;
  logic [CntW-1:0] since_result_q;
  logic [CntW-1:0] since_blink_q;
  logic            visible_q;
  logic            match_q;

  res_t            expected_results [$];
  res_t            predicted;
  res_t            oldest;

  // Saturating millisecond counter
  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Map a ladder sample onto a button
  function automatic btn_e classify_adc(input logic [AdcW-1:0] adc);
    if (adc >= AdcNoneMin) return BTN_NONE;
    if (adc < AdcRightLim) return BTN_RIGHT;
    if (adc < AdcUpLim)    return BTN_UP;
    if (adc < AdcDownLim)  return BTN_DOWN;
    if (adc < AdcLeftLim)  return BTN_LEFT;
    return BTN_SELECT;
  endfunction

  // Advance the lock by one tick and form the result it shows afterwards
  task automatic step_lock(input logic [AdcW-1:0] adc, output res_t r);
    btn_e            seen;
    logic [NibW-1:0] d;
    logic [RegW-1:0] code;
    seen = BTN_NOT_SAMPLED;
    since_sample_q = bump(since_sample_q);
    since_result_q = bump(since_result_q);
    since_blink_q  = bump(since_blink_q);
    d = digit_q[cursor_q];
    case (lock_phase)
      PH_INIT: lock_phase = PH_ENTRY;
      PH_ENTRY: begin
        if (since_sample_q > {1'b0, sample_q}) begin
          seen = classify_adc(adc);
          case (seen)
            BTN_RIGHT:  cursor_q = cursor_q + 2'd1;
            BTN_LEFT:   cursor_q = cursor_q - 2'd1;
            BTN_UP:     digit_q[cursor_q] = (d == DigitMax) ? '0 : d + 1'b1;
            BTN_DOWN:   digit_q[cursor_q] = (d == '0) ? DigitMax : d - 1'b1;
            BTN_SELECT: lock_phase = PH_CHECK;
            default: ;
          endcase
          since_sample_q = '0;
        end
        // blink runs in entry only, after the button action
        if (since_blink_q > {1'b0, blink_q}) begin
          visible_q     = ~visible_q;
          since_blink_q = '0;
        end
      end
      PH_CHECK: begin
        match_q = 1'b1;
        for (int i = 0; i < DigitsDefault; i++) begin
          if (digit_q[i] != secret_q[i*NibW +: NibW]) match_q = 1'b0;
        end
        since_result_q = '0;
        lock_phase     = PH_SHOW;
      end
      PH_SHOW: begin
        if (since_result_q > {1'b0, hold_q}) lock_phase = match_q ? PH_SOLVED : PH_INIT;
      end
      default: lock_phase = PH_SOLVED;
    endcase
    code = '0;
    for (int i = 0; i < DigitsDefault; i++) code[i*NibW +: NibW] = digit_q[i];
    r.phase         = lock_phase;
    r.entered_code  = code;
    r.cursor        = cursor_q;
    r.digit_visible = visible_q;
    r.code_correct  = match_q;
    r.solved        = (lock_phase == PH_SOLVED);
    r.button_seen   = seen;
  endtask

  // Report one field that differs
  task automatic compare_field(input string name, input logic [RegW-1:0] want,
                               input logic [RegW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  // Track writes, predict on each tick item, compare on each result item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secret_q       = SecretRst;
      sample_q       = SampleRst;
      hold_q         = HoldRst;
      blink_q        = BlinkRst;
      lock_phase     = PH_INIT;
      for (int i = 0; i < DigitsDefault; i++) digit_q[i] = '0;
      cursor_q       = '0;
      since_sample_q = '0;
      since_result_q = '0;
      since_blink_q  = '0;
      visible_q      = 1'b1;
      match_q        = 1'b1;
      expected_results.delete();
      mismatches_o   = 0;
      outstanding_o  = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_SECRET: secret_q = cfg_i.data;
          CFG_SAMPLE: sample_q = cfg_i.data;
          CFG_HOLD:   hold_q   = cfg_i.data;
          CFG_BLINK:  blink_q  = cfg_i.data;
          default: ;
        endcase
      end
      if (tick_i.valid && tick_i.ready) begin
        step_lock(tick_i.button_adc, predicted);
        expected_results.push_back(predicted);
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result item with none expected, phase %0h code %0h", $time,
                   res_i.phase, res_i.entered_code);
          mismatches_o++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("phase", RegW'(oldest.phase), RegW'(res_i.phase));
          compare_field("entered_code", oldest.entered_code, res_i.entered_code);
          compare_field("cursor", RegW'(oldest.cursor), RegW'(res_i.cursor));
          compare_field("digit_visible", RegW'(oldest.digit_visible),
                        RegW'(res_i.digit_visible));
          compare_field("code_correct", RegW'(oldest.code_correct),
                        RegW'(res_i.code_correct));
          compare_field("solved", RegW'(oldest.solved), RegW'(res_i.solved));
          compare_field("button_seen", RegW'(oldest.button_seen), RegW'(res_i.button_seen));
        end
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

/* tb/sv/digit_code_lock_entry_unit_tb.sv */
// ----------------------------------------------------------------------------
// digit_code_lock_entry_unit_tb: top level bench for the lock entry unit
// Drives tick items and register writes with random gaps and result stalls,
// runs directed button edges, random entry sessions, a near-miss code, the
// longest intervals and finally a correct code, then reports the verdict.
// ----------------------------------------------------------------------------
module digit_code_lock_entry_unit_tb
  import dcl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 20_000;
  localparam int unsigned GapPct        = 14;
  localparam int unsigned ResetTicks    = 250;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PhaseTicks    = 35;
  localparam int unsigned CalmPhase     = 3;
  localparam int unsigned NearMissTicks = 40;
  localparam int unsigned LongTicks     = 20;
  localparam logic [RegW-1:0] SecretTop = 16'h9999;
  localparam logic [RegW-1:0] RegMax    = '1;

  // Button edges first, then ticks that land in check, show and init
  localparam logic [AdcW-1:0] DirectedAdc [19] = '{
    10'd1023, 10'd1020, 10'd0, 10'd99, 10'd100, 10'd299, 10'd300, 10'd549,
    10'd550, 10'd799, 10'd1019, 10'd1023, 10'd1023, 10'd1023, 10'd800,
    10'd682, 10'd341, 10'd1023, 10'd0
  };

  logic        clk;
  logic        rst_n;
  bit          no_gaps;
  int unsigned ticks_sent;
  int unsigned results_seen;
  logic [RegW-1:0] last_code;
  int unsigned mismatches;
  int unsigned outstanding;

  dcl_tick_if   tick_ch ();
  dcl_result_if res_ch ();
  dcl_cfg_if    cfg_ch ();

  digit_code_lock_entry_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  lock_result_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .tick_i        (tick_ch),
    .res_i         (res_ch),
    .cfg_i         (cfg_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Result side: count items taken, keep the last code, stall at random
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        last_code = res_ch.entered_code;
      end
      res_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GapPct);
    end
  end

  // Ladder sample in a random button band; select with the given percentage
  function automatic logic [AdcW-1:0] pick_adc(input int unsigned select_pct);
    if ($urandom_range(0, 99) < select_pct)
      return AdcW'($urandom_range(int'(AdcLeftLim), int'(AdcNoneMin) - 1));
    case ($urandom_range(0, 4))
      0:       return AdcW'($urandom_range(int'(AdcNoneMin), (1 << AdcW) - 1));
      1:       return AdcW'($urandom_range(0, int'(AdcRightLim) - 1));
      2:       return AdcW'($urandom_range(int'(AdcRightLim), int'(AdcUpLim) - 1));
      3:       return AdcW'($urandom_range(int'(AdcUpLim), int'(AdcDownLim) - 1));
      default: return AdcW'($urandom_range(int'(AdcDownLim), int'(AdcLeftLim) - 1));
    endcase
  endfunction

  // Secret with a nibble above nine, so no entered code can ever match it
  function automatic logic [RegW-1:0] bad_secret();
    logic [RegW-1:0] s;
    int unsigned     k;
    s = RegW'($urandom_range(0, 16'h8FFF));
    k = $urandom_range(0, CodeNib - 2);
    s[k*NibW +: NibW] = NibW'($urandom_range(DigitBase, (1 << NibW) - 1));
    return s;
  endfunction

  // Offer one tick item after an optional gap; hold valid until taken
  task automatic send_tick(input logic [AdcW-1:0] adc);
    while (!no_gaps && ($urandom_range(0, 99) < GapPct)) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.button_adc <= adc;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [RegW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_lock(input logic [RegW-1:0] secret, input logic [RegW-1:0] sample,
                              input logic [RegW-1:0] hold, input logic [RegW-1:0] blink);
    write_reg(CFG_SECRET, secret);
    write_reg(CFG_SAMPLE, sample);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_BLINK, blink);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid and wait until every tick item has its result back
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (results_seen != ticks_sent) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [RegW-1:0] target;
    int unsigned     k;
    rst_n              <= 1'b0;
    tick_ch.valid      <= 1'b0;
    tick_ch.button_adc <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_SECRET;
    cfg_ch.data        <= '0;
    no_gaps      = 1'b0;
    ticks_sent   = 0;
    results_seen = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers; keep off select, since the zero code would match
    repeat (ResetTicks) send_tick(pick_adc(0));

    // Secret extremes, then shortest intervals with the directed edges
    wait_drained();
    program_lock(SecretTop, SampleRst, HoldRst, BlinkRst);
    program_lock('0, SampleRst, HoldRst, BlinkRst);
    program_lock(bad_secret(), '0, '0, '0);
    foreach (DirectedAdc[i]) send_tick(DirectedAdc[i]);

    // Random entry sessions with short intervals; one without any gaps
    for (int p = 0; p < RandomPhases; p++) begin
      wait_drained();
      no_gaps = (p == CalmPhase);
      program_lock(bad_secret(), RegW'($urandom_range(0, 3)), RegW'($urandom_range(0, 6)),
                   RegW'($urandom_range(0, 9)));
      repeat (PhaseTicks) send_tick(pick_adc(6));
    end
    no_gaps = 1'b0;

    // Near miss: entered code with one digit stepped, select only
    wait_drained();
    target = last_code;
    k = $urandom_range(0, DigitsDefault - 1);
    target[k*NibW +: NibW] = (target[k*NibW +: NibW] == DigitMax) ? '0 :
                             target[k*NibW +: NibW] + 1'b1;
    program_lock(target, RegW'(1), RegW'(2), RegW'(3));
    repeat (NearMissTicks) send_tick(pick_adc(100));

    // Longest intervals: no wait runs out within these ticks
    wait_drained();
    program_lock(bad_secret(), RegMax, RegMax, RegMax);
    repeat (LongTicks) send_tick(pick_adc(100));

    // Correct code last, since solved never leaves
    wait_drained();
    no_gaps = 1'b1;
    program_lock(last_code, RegW'(1), RegW'(3), RegW'(2));
    repeat (30) send_tick(pick_adc(100));
    repeat (20) send_tick(pick_adc(10));

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dcl_pkg.sv
rtl/dcl_if.sv
rtl/dcl_btn_dec.sv
rtl/digit_code_lock_entry_unit.sv
tb/sv/lock_result_checker.sv
tb/sv/digit_code_lock_entry_unit_tb.sv
